// File: hw/rtl/spoq_pkg.sv
// Shared types and constants of the stable priority ordered queue.
package spoq_pkg;

  localparam int unsigned Depth     = 16;
  localparam int unsigned PrioBits  = 8;
  localparam int unsigned MaxShown  = 16;

  // Priority bits that are actually kept: the request field is 8 bits wide.
  localparam int unsigned StoreBits = (PrioBits < 8) ? PrioBits : 8;
  localparam int unsigned CntW      = $clog2(Depth + 1);
  localparam int unsigned RotW      = $clog2(Depth);

  typedef enum logic {
    KindInsert  = 1'b0,
    KindDisplay = 1'b1
  } spoq_kind_e;

  typedef enum logic [1:0] {
    StatInserted = 2'd0,
    StatDropped  = 2'd1,
    StatShown    = 2'd2,
    StatEmpty    = 2'd3
  } spoq_status_e;

  typedef enum logic {
    StIdle = 1'b0,
    StShow = 1'b1
  } spoq_state_e;

  typedef struct packed {
    logic               kind;
    logic signed [31:0] value;
    logic        [7:0]  priority_req;
  } spoq_req_t;

  typedef struct packed {
    logic        [1:0]  status;
    logic signed [31:0] value_res;
    logic        [7:0]  priority_res;
    logic        [3:0]  position;
    logic               last;
  } spoq_res_t;

  typedef struct packed {
    logic [31:0]          value;
    logic [StoreBits-1:0] prio;
  } spoq_entry_t;

  typedef struct packed {
    logic insert;
    logic rotate;
  } spoq_ctrl_t;

endpackage

// File: hw/rtl/spoq_cell.sv
// One storage cell of the queue chain: compare, shift on insert, rotate on display.
module spoq_cell (
  input  logic                 clk_i,
  input  spoq_pkg::spoq_ctrl_t ctrl_i,
  input  logic                 valid_i,
  input  spoq_pkg::spoq_entry_t new_i,
  input  spoq_pkg::spoq_entry_t left_i,
  input  logic                 left_gt_i,
  input  spoq_pkg::spoq_entry_t right_i,
  output spoq_pkg::spoq_entry_t entry_o,
  output logic                 gt_o
);

  spoq_pkg::spoq_entry_t entry_q, entry_d;

  // An empty cell counts as greater, so the first free cell takes a new entry.
  assign gt_o = !valid_i || (entry_q.prio > new_i.prio);

  always_comb begin
    entry_d = entry_q;
    if (ctrl_i.rotate) begin
      entry_d = right_i;
    end else if (ctrl_i.insert) begin
      if (left_gt_i) begin
        entry_d = left_i;
      end else if (gt_o) begin
        entry_d = new_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;

endmodule

// File: hw/rtl/stable_priority_ordered_queue.sv
// Top level of the stable priority ordered queue built from a chain of cells.
//
// The queue holds up to spoq_pkg::Depth entries sorted by ascending priority,
// first come, first out within one priority. A request is taken when start is
// high and busy is low. On an insert request all cells compare the new
// priority at once, the entries behind the insertion point shift one cell
// toward the tail, and one status result (inserted or dropped because full)
// appears on res_o with done_o high in the next cycle. A display request on
// an empty queue gives one empty status in the next cycle. Otherwise the
// chain rotates toward the head once per cycle for Depth steps, the head
// cell is shown in each of the first min(count, 16) steps, and the entries
// end up back in their places; busy stays high through those steps. Every
// result is on res_o for exactly one cycle and cannot be held off, and the
// final result of a request carries the last flag.
module stable_priority_ordered_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  spoq_pkg::spoq_req_t req_i,
  output logic                done_o,
  output spoq_pkg::spoq_res_t res_o
);

  spoq_pkg::spoq_state_e state_q, state_d;
  logic [spoq_pkg::CntW-1:0] entry_cnt_q, entry_cnt_d;
  logic [spoq_pkg::RotW-1:0] rot_cnt_q, rot_cnt_d;
  logic                      done_q, done_d;
  spoq_pkg::spoq_res_t       res_q, res_d;

  spoq_pkg::spoq_ctrl_t  ctrl;
  spoq_pkg::spoq_entry_t new_entry;
  spoq_pkg::spoq_entry_t entries [spoq_pkg::Depth];
  logic [spoq_pkg::Depth-1:0] gt;
  logic [spoq_pkg::Depth-1:0] valid;

  logic                      accept;
  logic                      full;
  logic [spoq_pkg::CntW-1:0] shown;

  assign accept = start && !busy;
  assign full   = (32'(entry_cnt_q) >= spoq_pkg::Depth);

  // Only the low priority bits that the store keeps take part in ordering.
  assign new_entry.value = req_i.value;
  assign new_entry.prio  = req_i.priority_req[spoq_pkg::StoreBits-1:0];

  // At most MaxShown entries are shown per display request.
  always_comb begin
    if (32'(entry_cnt_q) < spoq_pkg::MaxShown) begin
      shown = entry_cnt_q;
    end else begin
      shown = spoq_pkg::CntW'(spoq_pkg::MaxShown);
    end
  end

  // The chain itself: each cell sees its left neighbor for an insert shift and
  // its right neighbor for the display rotation; the tail wraps to the head.
  for (genvar i = 0; i < spoq_pkg::Depth; i++) begin : g_cell
    logic                  left_gt;
    spoq_pkg::spoq_entry_t left_entry;
    spoq_pkg::spoq_entry_t right_entry;

    assign valid[i] = (i < 32'(entry_cnt_q));

    if (i == 0) begin : g_head
      assign left_gt    = 1'b0;
      assign left_entry = new_entry;
    end else begin : g_body
      assign left_gt    = gt[i-1];
      assign left_entry = entries[i-1];
    end

    if (i == spoq_pkg::Depth - 1) begin : g_tail
      assign right_entry = entries[0];
    end else begin : g_inner
      assign right_entry = entries[i+1];
    end

    spoq_cell u_cell (
      .clk_i    (clk_i),
      .ctrl_i   (ctrl),
      .valid_i  (valid[i]),
      .new_i    (new_entry),
      .left_i   (left_entry),
      .left_gt_i(left_gt),
      .right_i  (right_entry),
      .entry_o  (entries[i]),
      .gt_o     (gt[i])
    );
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      spoq_pkg::StIdle: begin
        if (accept && req_i.kind == spoq_pkg::KindDisplay && entry_cnt_q != '0) begin
          state_d = spoq_pkg::StShow;
        end
      end
      spoq_pkg::StShow: begin
        if (rot_cnt_q == spoq_pkg::RotW'(spoq_pkg::Depth - 1)) begin
          state_d = spoq_pkg::StIdle;
        end
      end
      default: state_d = spoq_pkg::StIdle;
    endcase
  end

  // Outputs of the state machine: cell controls, counters and the next result.
  always_comb begin
    ctrl        = '0;
    entry_cnt_d = entry_cnt_q;
    rot_cnt_d   = '0;
    done_d      = 1'b0;
    res_d       = '0;
    busy        = 1'b0;
    case (state_q)
      spoq_pkg::StIdle: begin
        if (accept) begin
          done_d     = 1'b1;
          res_d.last = 1'b1;
          if (req_i.kind == spoq_pkg::KindInsert) begin
            if (full) begin
              res_d.status = spoq_pkg::StatDropped;
            end else begin
              ctrl.insert  = 1'b1;
              entry_cnt_d  = entry_cnt_q + 1'b1;
              res_d.status = spoq_pkg::StatInserted;
            end
          end else if (entry_cnt_q == '0) begin
            res_d.status = spoq_pkg::StatEmpty;
          end else begin
            // The display results start in the show state.
            done_d     = 1'b0;
            res_d.last = 1'b0;
          end
        end
      end
      spoq_pkg::StShow: begin
        busy        = 1'b1;
        ctrl.rotate = 1'b1;
        // The counter returns to zero after the final rotation step.
        if (rot_cnt_q != spoq_pkg::RotW'(spoq_pkg::Depth - 1)) begin
          rot_cnt_d = rot_cnt_q + 1'b1;
        end
        if (32'(rot_cnt_q) < 32'(shown)) begin
          done_d             = 1'b1;
          res_d.status       = spoq_pkg::StatShown;
          res_d.value_res    = entries[0].value;
          res_d.priority_res = 8'(entries[0].prio);
          res_d.position     = 4'(rot_cnt_q);
          res_d.last         = (32'(rot_cnt_q) + 32'd1 == 32'(shown));
        end
      end
      default: begin
        busy = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= spoq_pkg::StIdle;
      entry_cnt_q <= '0;
      rot_cnt_q   <= '0;
      done_q      <= 1'b0;
    end else begin
      state_q     <= state_d;
      entry_cnt_q <= entry_cnt_d;
      rot_cnt_q   <= rot_cnt_d;
      done_q      <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign done_o = done_q;
  assign res_o  = res_q;

  // The fill count never passes the number of cells.
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(entry_cnt_q) <= spoq_pkg::Depth)
    else $error("entry count exceeds depth");

  // An insert into a queue with room grows the count by exactly one.
  a_insert_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && req_i.kind == spoq_pkg::KindInsert && !full)
    |=> entry_cnt_q == $past(entry_cnt_q) + 1'b1)
    else $error("insert did not grow the count");

  // An insert status only follows an accepted insert request.
  a_status_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (res_o.status == spoq_pkg::StatInserted ||
                res_o.status == spoq_pkg::StatDropped))
    |-> $past(accept) && $past(req_i.kind) == spoq_pkg::KindInsert)
    else $error("insert status without an insert request");

  // The rotation counter is at rest whenever the block is free.
  a_rot_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy |-> rot_cnt_q == '0)
    else $error("rotation counter not at rest while idle");

endmodule
